>>> sv/gfp_pkg.sv
// gfp_pkg: shared types, constants and the byte-wise CRC16 update for the
// gyro frame parser. No dependencies.
package gfp_pkg;

    localparam logic [7:0]  FRAME_ADDR = 8'h0A;
    localparam logic [7:0]  FRAME_FUNC = 8'h03;
    localparam logic [7:0]  FRAME_LEN  = 8'h04;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    // result status codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_GOOD   = 2'd1;
    localparam logic [1:0] ST_FORMAT = 2'd2;
    localparam logic [1:0] ST_CRC    = 2'd3;

    // classified byte event, front to back
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] angle;
        logic [15:0] rate;
    } event_t;

    // Modbus CRC16, reflected, one byte
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> sv/gfp_front.sv
// gfp_front: frame hunter. Tracks the frame position, running CRC and held
// payload bytes, and turns each accepted byte into a gfp_pkg::event_t.
module gfp_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    output logic              push_valid,
    input  logic              push_ready,
    output gfp_pkg::event_t   push_data
);

    // frame position: index of the next expected frame byte
    localparam logic [3:0] POS_IDLE    = 4'd0;
    localparam logic [3:0] POS_FUNC    = 4'd1;
    localparam logic [3:0] POS_LEN     = 4'd2;
    localparam logic [3:0] POS_ANG_HI  = 4'd3;
    localparam logic [3:0] POS_ANG_LO  = 4'd4;
    localparam logic [3:0] POS_RATE_HI = 4'd5;
    localparam logic [3:0] POS_RATE_LO = 4'd6;
    localparam logic [3:0] POS_CRC_LO  = 4'd7;
    localparam logic [3:0] POS_CRC_HI  = 4'd8;

    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [31:0] payload_reg;
    logic [31:0] payload_next;
    logic [7:0]  crc_low_reg;
    logic [7:0]  crc_low_next;
    logic        accept;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid & push_ready;

    always_comb
    begin
        pos_next         = pos_reg;
        crc_next         = crc_reg;
        payload_next     = payload_reg;
        crc_low_next     = crc_low_reg;
        push_data.status = gfp_pkg::ST_IDLE;
        push_data.angle  = payload_reg[31:16];
        push_data.rate   = payload_reg[15:0];
        unique case (pos_reg) inside
            POS_FUNC, POS_LEN:
            begin
                if (rx_byte != ((pos_reg == POS_FUNC) ? gfp_pkg::FRAME_FUNC
                                                      : gfp_pkg::FRAME_LEN))
                begin
                    push_data.status = gfp_pkg::ST_FORMAT;
                    // resync; a stray address byte starts a new frame
                    if (rx_byte == gfp_pkg::FRAME_ADDR)
                    begin
                        pos_next = POS_FUNC;
                        crc_next = gfp_pkg::crc_feed(gfp_pkg::CRC_INIT, rx_byte);
                    end
                    else
                    begin
                        pos_next = POS_IDLE;
                        crc_next = gfp_pkg::CRC_INIT;
                    end
                end
                else
                begin
                    crc_next = gfp_pkg::crc_feed(crc_reg, rx_byte);
                    pos_next = pos_reg + 4'd1;
                end
            end
            POS_ANG_HI, POS_ANG_LO, POS_RATE_HI, POS_RATE_LO:
            begin
                crc_next     = gfp_pkg::crc_feed(crc_reg, rx_byte);
                payload_next = {payload_reg[23:0], rx_byte};
                pos_next     = pos_reg + 4'd1;
            end
            POS_CRC_LO:
            begin
                crc_low_next = rx_byte;
                pos_next     = POS_CRC_HI;
            end
            POS_CRC_HI:
            begin
                if ({rx_byte, crc_low_reg} == crc_reg)
                begin
                    push_data.status = gfp_pkg::ST_GOOD;
                end
                else
                begin
                    push_data.status = gfp_pkg::ST_CRC;
                end
                pos_next = POS_IDLE;
                crc_next = gfp_pkg::CRC_INIT;
            end
            default:
            begin
                // idle (and unreachable positions): wait for an address byte
                if (rx_byte == gfp_pkg::FRAME_ADDR)
                begin
                    pos_next = POS_FUNC;
                    crc_next = gfp_pkg::crc_feed(gfp_pkg::CRC_INIT, rx_byte);
                end
                else
                begin
                    pos_next = POS_IDLE;
                    crc_next = gfp_pkg::CRC_INIT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_IDLE;
            crc_reg <= gfp_pkg::CRC_INIT;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            payload_reg <= payload_next;
            crc_low_reg <= crc_low_next;
        end
    end

endmodule

>>> sv/gfp_queue.sv
// gfp_queue: small FIFO of gfp_pkg::event_t between front and back.
// Push and pop may happen in the same cycle.
module gfp_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  gfp_pkg::event_t   push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output gfp_pkg::event_t   pop_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    gfp_pkg::event_t mem [DEPTH];
    logic [IW-1:0]   wr_ptr_reg;
    logic [IW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid & push_ready;
    assign pop        = pop_valid & pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == IW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == IW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> sv/gfp_back.sv
// gfp_back: applies events to the published values and counters and holds
// the result register. Uses gfp_pkg.
module gfp_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  gfp_pkg::event_t   pop_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic signed [15:0] angle_raw,
    output logic signed [15:0] rate_raw,
    output logic [31:0]       frame_sequence,
    output logic [31:0]       format_error_count,
    output logic [31:0]       crc_error_count
);

    logic        valid_reg;
    logic [1:0]  status_reg;
    logic [15:0] angle_reg;
    logic [15:0] rate_reg;
    logic [31:0] good_reg;
    logic [31:0] fmt_reg;
    logic [31:0] crcerr_reg;
    logic        load;

    // counters only move when a new result loads, so they hold under stall
    assign pop_ready = !valid_reg || out_ready;
    assign load      = pop_valid && pop_ready;

    assign out_valid          = valid_reg;
    assign status             = status_reg;
    assign angle_raw          = angle_reg;
    assign rate_raw           = rate_reg;
    assign frame_sequence     = good_reg;
    assign format_error_count = fmt_reg;
    assign crc_error_count    = crcerr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            status_reg <= gfp_pkg::ST_IDLE;
            angle_reg  <= '0;
            rate_reg   <= '0;
            good_reg   <= '0;
            fmt_reg    <= '0;
            crcerr_reg <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg  <= 1'b1;
                status_reg <= pop_data.status;
                unique case (pop_data.status)
                    gfp_pkg::ST_GOOD:
                    begin
                        angle_reg <= pop_data.angle;
                        rate_reg  <= pop_data.rate;
                        good_reg  <= good_reg + 32'd1;
                    end
                    gfp_pkg::ST_FORMAT:
                    begin
                        fmt_reg <= fmt_reg + 32'd1;
                    end
                    gfp_pkg::ST_CRC:
                    begin
                        crcerr_reg <= crcerr_reg + 32'd1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> sv/gyro_frame_parser_crc16.sv
// gyro_frame_parser_crc16: byte-serial parser for 9-byte gyro frames
// (0x0A 0x03 0x04, angle, rate, Modbus CRC16 low byte first).
// Usage:
//   in channel  : in_valid/in_ready with rx_byte, one received UART byte per
//                 transfer.
//   out channel : out_valid/out_ready; exactly one result per input byte:
//                 status (0 idle/in progress, 1 good frame, 2 format error,
//                 3 crc error), the last good angle and rate, and the good
//                 frame, format error and crc error counters (all wrap).
// Throughput: one byte per cycle while in_ready is high; the CRC update is
//   an 8-step XOR network in the front stage.
// Path: a byte accepted by the front is classified into the queue, and the
//   back then loads its result into the result register.
// Stall: when out_ready is low the result register holds; the queue absorbs
//   QUEUE_DEPTH more bytes, after which in_ready drops.
// Reset (rst_n low, async): parser idle, CRC at 0xFFFF, queue empty,
//   published angle/rate and all counters zero, no result pending.
module gyro_frame_parser_crc16
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [15:0] angle_raw,
    output logic signed [15:0] rate_raw,
    output logic [31:0]        frame_sequence,
    output logic [31:0]        format_error_count,
    output logic [31:0]        crc_error_count
);

    logic            push_valid;
    logic            push_ready;
    gfp_pkg::event_t push_data;
    logic            pop_valid;
    logic            pop_ready;
    gfp_pkg::event_t pop_data;

    // front: frame position, running CRC, payload capture
    gfp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decoupling queue of classified events
    gfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back: publish, count, result register
    gfp_back u_back
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .pop_valid          (pop_valid),
        .pop_ready          (pop_ready),
        .pop_data           (pop_data),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .angle_raw          (angle_raw),
        .rate_raw           (rate_raw),
        .frame_sequence     (frame_sequence),
        .format_error_count (format_error_count),
        .crc_error_count    (crc_error_count)
    );

endmodule

>>> sim/gfp_frame_checker.sv
// gfp_frame_checker.sv: CRC helper package for the gyro frame parser bench, and the
// checker that predicts one result per accepted byte and compares the output channel.
// Depends on gfp_pkg (frame constants, status codes).
package gfp_tb_pkg;
    import gfp_pkg::*;

    // Modbus CRC16, shifted in one data bit at a time, LSB first
    function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc,
                                                      input logic [7:0] data);
        logic [15:0] acc;
        logic        fb;
        int          i;
        acc = crc;
        for (i = 0; i < 8; i++)
        begin
            fb  = acc[0] ^ data[i];
            acc = acc >> 1;
            if (fb)
            begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

endpackage

module gfp_frame_checker
    import gfp_pkg::*;
    import gfp_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [15:0] angle_raw,
    input  logic [15:0] rate_raw,
    input  logic [31:0] frame_sequence,
    input  logic [31:0] format_error_count,
    input  logic [31:0] crc_error_count,
    output int          mismatches,
    output int          results_pending,
    output int          good_frames_seen,
    output int          format_errors_seen,
    output int          crc_errors_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] POS_IDLE     = 4'd0;
    localparam logic [3:0] POS_FUNC     = 4'd1;
    localparam logic [3:0] POS_LEN      = 4'd2;
    localparam logic [3:0] POS_LAST_PAY = 4'd6;
    localparam logic [3:0] POS_CRC_LO   = 4'd7;
    localparam logic [3:0] POS_CRC_HI   = 4'd8;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] angle;
        logic [15:0] rate;
        logic [31:0] frames;
        logic [31:0] format_errs;
        logic [31:0] crc_errs;
    } parser_result_t;

    // predicted parser state
    logic [3:0]  frame_pos;
    logic [15:0] crc_acc;
    logic [31:0] payload_bytes;
    logic [7:0]  crc_low_byte;
    logic [15:0] last_angle;
    logic [15:0] last_rate;
    logic [31:0] good_count;
    logic [31:0] format_count;
    logic [31:0] crc_fail_count;

    parser_result_t expected_results[$];
    int             results_seen;

    // an address byte opens a new frame, anything else leaves the parser idle
    task automatic resync_on(input logic [7:0] b);
        if (b == FRAME_ADDR)
        begin
            frame_pos = POS_FUNC;
            crc_acc   = crc16_modbus_byte(CRC_INIT, b);
        end
        else
        begin
            frame_pos = POS_IDLE;
            crc_acc   = CRC_INIT;
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        parser_result_t r;
        r.status = ST_IDLE;
        if (frame_pos == POS_IDLE || frame_pos > POS_CRC_HI)
        begin
            resync_on(b);
        end
        else if (frame_pos == POS_FUNC || frame_pos == POS_LEN)
        begin
            if (b != ((frame_pos == POS_FUNC) ? FRAME_FUNC : FRAME_LEN))
            begin
                format_count = format_count + 32'd1;
                r.status     = ST_FORMAT;
                resync_on(b);
            end
            else
            begin
                crc_acc   = crc16_modbus_byte(crc_acc, b);
                frame_pos = frame_pos + 4'd1;
            end
        end
        else if (frame_pos <= POS_LAST_PAY)
        begin
            crc_acc       = crc16_modbus_byte(crc_acc, b);
            payload_bytes = {payload_bytes[23:0], b};
            frame_pos     = frame_pos + 4'd1;
        end
        else if (frame_pos == POS_CRC_LO)
        begin
            crc_low_byte = b;
            frame_pos    = POS_CRC_HI;
        end
        else
        begin
            // CRC travels low byte first
            if ({b, crc_low_byte} == crc_acc)
            begin
                last_angle = payload_bytes[31:16];
                last_rate  = payload_bytes[15:0];
                good_count = good_count + 32'd1;
                r.status   = ST_GOOD;
            end
            else
            begin
                crc_fail_count = crc_fail_count + 32'd1;
                r.status       = ST_CRC;
            end
            frame_pos = POS_IDLE;
            crc_acc   = CRC_INIT;
        end
        r.angle       = last_angle;
        r.rate        = last_rate;
        r.frames      = good_count;
        r.format_errs = format_count;
        r.crc_errs    = crc_fail_count;
        expected_results.push_back(r);
    endtask

    task automatic check_result();
        parser_result_t want;
        if (expected_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("unexpected result %0d: status %0d with no byte outstanding",
                         results_seen, status);
            end
        end
        else
        begin
            want = expected_results.pop_front();
            if (status !== want.status || angle_raw !== want.angle
                || rate_raw !== want.rate || frame_sequence !== want.frames
                || format_error_count !== want.format_errs
                || crc_error_count !== want.crc_errs)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result %0d mismatch\n  expected st=%0d ang=%0d rate=%0d seq=%0d fmt=%0d crc=%0d\n  actual   st=%0d ang=%0d rate=%0d seq=%0d fmt=%0d crc=%0d",
                             results_seen, want.status, $signed(want.angle),
                             $signed(want.rate), want.frames, want.format_errs,
                             want.crc_errs, status, $signed(angle_raw),
                             $signed(rate_raw), frame_sequence,
                             format_error_count, crc_error_count);
                end
            end
            case (want.status)
                ST_GOOD:   good_frames_seen++;
                ST_FORMAT: format_errors_seen++;
                ST_CRC:    crc_errors_seen++;
                default:   ;
            endcase
        end
        results_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pos          = POS_IDLE;
            crc_acc            = CRC_INIT;
            payload_bytes      = '0;
            crc_low_byte       = '0;
            last_angle         = '0;
            last_rate          = '0;
            good_count         = '0;
            format_count       = '0;
            crc_fail_count     = '0;
            mismatches         = 0;
            results_seen       = 0;
            good_frames_seen   = 0;
            format_errors_seen = 0;
            crc_errors_seen    = 0;
            expected_results.delete();
        end
        else
        begin
            // compare first: a byte taken at this edge cannot answer before the next
            if (out_valid && out_ready)
            begin
                check_result();
            end
            if (in_valid && in_ready)
            begin
                parse_byte(rx_byte);
            end
        end
        results_pending = expected_results.size();
    end

endmodule

>>> sim/tb_gyro_frame_parser_crc16.sv
// tb_gyro_frame_parser_crc16.sv: top of the gyro frame parser bench. Drives byte
// streams (clean, corrupted, truncated and noisy frames) with random idling on both
// channels. Depends on gfp_pkg, gfp_tb_pkg, gfp_frame_checker and the parser RTL.
module tb_gyro_frame_parser_crc16;
    timeunit 1ns;
    timeprecision 1ps;

    import gfp_pkg::*;
    import gfp_tb_pkg::*;

    localparam int ITEM_TARGET  = 1350;   // byte transfers in the whole run
    localparam int PHASE_A_END  = 600;    // before the back-pressure test
    localparam int PHASE_B_END  = 1200;   // after this, no idling at all
    localparam int LONG_HOLD    = 100;    // cycles the sink refuses results
    localparam int DRAIN_CYCLES = 20;     // settle time after the last result
    localparam int CYCLE_LIMIT  = 200000; // watchdog

    // ways a generated frame can go wrong
    typedef enum {
        FLAW_NONE,
        FLAW_CRC,
        FLAW_FUNC,
        FLAW_LEN,
        FLAW_CUT
    } frame_flaw_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [1:0]  status;
    logic signed [15:0] angle_raw;
    logic signed [15:0] rate_raw;
    logic [31:0] frame_sequence;
    logic [31:0] format_error_count;
    logic [31:0] crc_error_count;

    int mismatches;
    int results_pending;
    int good_frames_seen;
    int format_errors_seen;
    int crc_errors_seen;

    int items_sent  = 0;
    int cycle_count = 0;

    // idling switches, flipped by the stimulus and read by both drivers
    bit src_gaps       = 1'b1;
    bit sink_stalls    = 1'b1;
    bit long_hold_req  = 1'b0;
    bit long_hold_done = 1'b0;

    gyro_frame_parser_crc16 uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .rx_byte            (rx_byte),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .angle_raw          (angle_raw),
        .rate_raw           (rate_raw),
        .frame_sequence     (frame_sequence),
        .format_error_count (format_error_count),
        .crc_error_count    (crc_error_count)
    );

    gfp_frame_checker frame_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .rx_byte            (rx_byte),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .angle_raw          (angle_raw),
        .rate_raw           (rate_raw),
        .frame_sequence     (frame_sequence),
        .format_error_count (format_error_count),
        .crc_error_count    (crc_error_count),
        .mismatches         (mismatches),
        .results_pending    (results_pending),
        .good_frames_seen   (good_frames_seen),
        .format_errors_seen (format_errors_seen),
        .crc_errors_seen    (crc_errors_seen)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_gyro_frame_parser_crc16 NOT OK");
            $finish;
        end
    end

    // Result sink. Each pass makes exactly one assignment to out_ready and then
    // waits at least one edge, so the ready line never gets two updates per step.
    // The long hold is counted here, independent of what the source is doing.
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold_req && !long_hold_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else if (sink_stalls && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offer one byte and hold it until the transfer. in_ready is read right after
    // the edge, before this edge's updates land, so it is the value the RTL saw.
    // Valid stays high on return; only a random gap lowers it.
    task automatic send_byte(input logic [7:0] b);
        rx_byte  <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (src_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom_range(0, 255));
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // angle/rate values, biased toward the signed extremes
    function automatic logic [15:0] pick_word();
        logic [15:0] w;
        w = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 11))
            0:       w = 16'h0000;
            1:       w = 16'h7FFF;
            2:       w = 16'h8000;
            3:       w = 16'hFFFF;
            default: ;
        endcase
        return w;
    endfunction

    // a header byte that is not the expected one; often an address byte, which
    // the parser must keep as the start of a new frame
    function automatic logic [7:0] wrong_byte(input logic [7:0] good);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 2) == 0)
        begin
            b = FRAME_ADDR;
        end
        if (b == good)
        begin
            b = b ^ 8'h80;
        end
        return b;
    endfunction

    // Build a 9-byte frame with a valid CRC, then damage it as asked.
    // A bad header byte ends the frame there; a cut ends it at a random byte.
    task automatic send_frame(input logic [15:0] angle, input logic [15:0] rate,
                              input frame_flaw_t flaw);
        logic [7:0]  frame_bytes [0:8];
        logic [15:0] crc;
        int          count;
        int          i;
        frame_bytes[0] = FRAME_ADDR;
        frame_bytes[1] = FRAME_FUNC;
        frame_bytes[2] = FRAME_LEN;
        frame_bytes[3] = angle[15:8];
        frame_bytes[4] = angle[7:0];
        frame_bytes[5] = rate[15:8];
        frame_bytes[6] = rate[7:0];
        crc = CRC_INIT;
        for (i = 0; i < 7; i++)
        begin
            crc = crc16_modbus_byte(crc, frame_bytes[i]);
        end
        frame_bytes[7] = crc[7:0];
        frame_bytes[8] = crc[15:8];
        count = 9;
        case (flaw)
            FLAW_CRC:
            begin
                // one flipped bit in payload or CRC; CRC16 catches any single-bit error
                i = $urandom_range(3, 8);
                frame_bytes[i] = frame_bytes[i] ^ (8'h01 << $urandom_range(0, 7));
            end
            FLAW_FUNC:
            begin
                frame_bytes[1] = wrong_byte(FRAME_FUNC);
                count = 2;
            end
            FLAW_LEN:
            begin
                frame_bytes[2] = wrong_byte(FRAME_LEN);
                count = 3;
            end
            FLAW_CUT:
            begin
                count = $urandom_range(1, 8);
            end
            default: ;
        endcase
        for (i = 0; i < count; i++)
        begin
            send_byte(frame_bytes[i]);
        end
    endtask

    // Mostly whole frames with random content; the rest is damaged frames,
    // header stutters that must resync, and raw line noise.
    task automatic run_random(input int stop_at, input bit vary_idling);
        int pick;
        while (items_sent < stop_at)
        begin
            // switch idling on and off now and then, for stretches without gaps
            if (vary_idling && $urandom_range(0, 9) == 0)
            begin
                src_gaps    = 1'($urandom_range(0, 1));
                sink_stalls = 1'($urandom_range(0, 1));
            end
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                send_frame(pick_word(), pick_word(), FLAW_NONE);
            end
            else if (pick < 62)
            begin
                send_frame(pick_word(), pick_word(), FLAW_CRC);
            end
            else if (pick < 68)
            begin
                send_frame(pick_word(), pick_word(), FLAW_FUNC);
            end
            else if (pick < 74)
            begin
                send_frame(pick_word(), pick_word(), FLAW_LEN);
            end
            else if (pick < 82)
            begin
                send_frame(pick_word(), pick_word(), FLAW_CUT);
            end
            else if (pick < 88)
            begin
                // stray header, then a whole frame: its address byte lands as a
                // bad function or length byte and has to be kept
                send_byte(FRAME_ADDR);
                if ($urandom_range(0, 1) == 1)
                begin
                    send_byte(FRAME_FUNC);
                end
                send_frame(pick_word(), pick_word(), FLAW_NONE);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        send_byte(FRAME_ADDR);
                    end
                    else
                    begin
                        send_byte(8'($urandom_range(0, 255)));
                    end
                end
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: idle bytes are ignored, a repeated address byte is a format
        // error that restarts the frame and still ends good, a bad length byte
        // is dropped, and a damaged frame gives a CRC error
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(FRAME_ADDR);
        send_frame(16'h8000, 16'h7FFF, FLAW_NONE);
        send_byte(FRAME_ADDR);
        send_byte(FRAME_FUNC);
        send_byte(8'hFF);
        send_frame(16'h7FFF, 16'h8000, FLAW_CRC);

        run_random(PHASE_A_END, 1'b0);

        // back-pressure: the sink holds off while the source keeps offering
        // back to back, so the parser queue fills and in_ready drops
        src_gaps      = 1'b0;
        sink_stalls   = 1'b0;
        long_hold_req = 1'b1;
        while (!long_hold_done)
        begin
            send_frame(pick_word(), pick_word(), FLAW_NONE);
        end

        // source pause until every outstanding result has come back
        in_valid <= 1'b0;
        @(posedge clk);
        wait (results_pending == 0);

        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        run_random(PHASE_B_END, 1'b1);

        // tail at full rate on both sides
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        run_random(ITEM_TARGET, 1'b0);

        in_valid <= 1'b0;
        @(posedge clk);
        wait (results_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d byte transfers: %0d good frames, %0d format errors, %0d crc errors",
                 items_sent, good_frames_seen, format_errors_seen, crc_errors_seen);
        $display("back-pressure hold of %0d cycles and a full drain mid-run; %0d mismatches",
                 LONG_HOLD, mismatches);
        if (mismatches == 0 && results_pending == 0)
        begin
            $display("tb_gyro_frame_parser_crc16 OK");
        end
        else
        begin
            $display("tb_gyro_frame_parser_crc16 NOT OK");
        end
        $finish;
    end

endmodule

>>> files.f
sv/gfp_pkg.sv
sv/gfp_front.sv
sv/gfp_queue.sv
sv/gfp_back.sv
sv/gyro_frame_parser_crc16.sv
sim/gfp_frame_checker.sv
sim/tb_gyro_frame_parser_crc16.sv
